>>> hw/rtl/iir_filter_order4_direct_form1_top_macros.svh
// Assertion macros for the fourth-order direct form I filter.
// Used by the top level only; no other dependencies.
`ifndef IIR_FILTER_ORDER4_DIRECT_FORM1_TOP_MACROS_SVH
`define IIR_FILTER_ORDER4_DIRECT_FORM1_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled during reset
`define IIRDF1_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("filter assertion failed");

// Next-cycle implication, disabled during reset
`define IIRDF1_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("filter assertion failed");

`else

`define IIRDF1_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define IIRDF1_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

>>> hw/rtl/iirdf1_pkg.sv
// Shared types and constants for the fourth-order direct form I filter.
// No dependencies.
package iirdf1_pkg;

    // Filter orders (each 1..4); history depth stays at four
    localparam int FF_ORDER   = 4;
    localparam int FB_ORDER   = 4;
    localparam int HIST_DEPTH = 4;
    localparam int FF_TAPS    = 5;
    localparam int FB_TAPS    = 4;

    // Field and datapath widths
    localparam int SAMPLE_W = 12;
    localparam int COEF_W   = 32;
    localparam int Y_W      = 40;
    localparam int OPND_W   = 25;
    localparam int PROD_W   = COEF_W + OPND_W;
    localparam int FB_SUM_W = PROD_W + 17;
    localparam int ACC_W    = 46;
    localparam int FV_W     = 24;
    localparam int DAC_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int TAP_W      = 3;
    localparam int HIST_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEFF_0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEFF_1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEFF_2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEFF_3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FF_COEFF_4    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEFFS_1_2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FB_COEFFS_3_4 = 3'd6;

    // Saturation bounds of y (signed Q24.16)
    localparam logic signed [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
    localparam logic signed [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};

    typedef logic signed [COEF_W-1:0] coef_t;

    // What the MAC does with the product it is handed
    typedef enum logic [1:0] {
        KIND_FF,
        KIND_FB_LO,
        KIND_FB_HI
    } mac_kind_t;

    typedef struct packed {
        logic      clear;
        logic      mul_en;
        mac_kind_t kind;
    } mac_op_t;

endpackage

>>> hw/rtl/iir_filter_order4_direct_form1_top.sv
// Fourth-order IIR filter in direct form I (top level; uses iirdf1_pkg,
// iirdf1_cfg, iirdf1_mac and the assertion macro header). Each accepted
// 12-bit sample is run through one shared 32x25 multiply-accumulate unit:
// five feed-forward products, then each feedback tap as two half products
// (low 16 bits and high 24 bits of the stored Q24.16 output). A new sample
// is accepted only in the idle state, after the previous sample's result has
// been written. The result sits in an output register, so a new sample is
// taken while it waits; the next result is written only once the old one
// has been transferred. The user writes coefficients through the cfg port
// only while the filter is idle; the block itself does not enforce it.
`include "iir_filter_order4_direct_form1_top_macros.svh"

module iir_filter_order4_direct_form1_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [iirdf1_pkg::SAMPLE_W-1:0]        adc_sample,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic signed [iirdf1_pkg::FV_W-1:0]     filtered_value,
    output logic [iirdf1_pkg::DAC_W-1:0]           dac_code,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [iirdf1_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [iirdf1_pkg::CFG_DATA_W-1:0]      cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FF,
        S_FB_LO,
        S_FB_HI,
        S_DRAIN,
        S_FIN
    } state_t;

    state_t                                     state_reg;
    logic [iirdf1_pkg::TAP_W-1:0]               tap_reg;
    logic [iirdf1_pkg::TAP_W-1:0]               tap_m1;
    logic [iirdf1_pkg::HIST_IDX_W-1:0]          hidx;
    logic [iirdf1_pkg::SAMPLE_W-1:0]            x0_reg;
    logic [iirdf1_pkg::SAMPLE_W-1:0]            x_hist_reg [iirdf1_pkg::HIST_DEPTH];
    logic signed [iirdf1_pkg::Y_W-1:0]          y_hist_reg [iirdf1_pkg::HIST_DEPTH];
    logic                                       out_valid_reg;
    logic signed [iirdf1_pkg::FV_W-1:0]         fv_reg;
    logic [iirdf1_pkg::DAC_W-1:0]               dac_reg;

    iirdf1_pkg::coef_t                          ff_coeff [iirdf1_pkg::FF_TAPS];
    iirdf1_pkg::coef_t                          fb_coeff [iirdf1_pkg::FB_TAPS];
    iirdf1_pkg::mac_op_t                        mac_op;
    iirdf1_pkg::coef_t                          mac_coef;
    logic signed [iirdf1_pkg::OPND_W-1:0]       mac_operand;
    logic signed [iirdf1_pkg::ACC_W-1:0]        acc;

    logic                                       in_xfer;
    logic                                       fin_go;
    logic                                       acc_ovf;
    logic signed [iirdf1_pkg::Y_W-1:0]          y_sat;
    logic [iirdf1_pkg::SAMPLE_W-1:0]            x_sel;
    logic signed [iirdf1_pkg::Y_W-1:0]          y_sel;
    logic signed [iirdf1_pkg::FV_W-1:0]         fv_next;
    logic [iirdf1_pkg::DAC_W-1:0]               dac_next;

    // Coefficient registers
    assign cfg_ready = 1'b1;

    iirdf1_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .ff_coeff (ff_coeff),
        .fb_coeff (fb_coeff)
    );

    // Handshake
    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign fin_go    = (state_reg == S_FIN) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign filtered_value = fv_reg;
    assign dac_code       = dac_reg;

    // Operand selection for the shared MAC
    assign tap_m1 = tap_reg - 3'd1;
    assign hidx   = tap_m1[iirdf1_pkg::HIST_IDX_W-1:0];
    assign x_sel  = (tap_reg == '0) ? x0_reg : x_hist_reg[hidx];
    assign y_sel  = y_hist_reg[hidx];

    always_comb
    begin
        mac_op.clear  = in_xfer;
        mac_op.mul_en = 1'b0;
        mac_op.kind   = iirdf1_pkg::KIND_FF;
        mac_coef      = ff_coeff[tap_reg];
        mac_operand   = $signed({13'd0, x_sel});
        unique case (state_reg)
            S_FF:
            begin
                mac_op.mul_en = 1'b1;
            end
            S_FB_LO:
            begin
                mac_op.mul_en = 1'b1;
                mac_op.kind   = iirdf1_pkg::KIND_FB_LO;
                mac_coef      = fb_coeff[hidx];
                mac_operand   = $signed({9'd0, y_sel[15:0]});
            end
            S_FB_HI:
            begin
                mac_op.mul_en = 1'b1;
                mac_op.kind   = iirdf1_pkg::KIND_FB_HI;
                mac_coef      = fb_coeff[hidx];
                mac_operand   = $signed({y_sel[iirdf1_pkg::Y_W-1],
                                         y_sel[iirdf1_pkg::Y_W-1:16]});
            end
            default:
            begin
            end
        endcase
    end

    iirdf1_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (mac_op),
        .coef    (mac_coef),
        .operand (mac_operand),
        .acc     (acc)
    );

    // Saturate to 40 bits, then derive integer part and DAC code
    assign acc_ovf = (acc[iirdf1_pkg::ACC_W-1:iirdf1_pkg::Y_W-1] != '0) &&
                     (acc[iirdf1_pkg::ACC_W-1:iirdf1_pkg::Y_W-1] != '1);

    always_comb
    begin
        if (acc_ovf)
        begin
            y_sat = acc[iirdf1_pkg::ACC_W-1] ? iirdf1_pkg::Y_MIN : iirdf1_pkg::Y_MAX;
        end
        else
        begin
            y_sat = acc[iirdf1_pkg::Y_W-1:0];
        end

        // truncate toward zero: floor, plus one for a negative non-integer
        fv_next = $signed(y_sat[iirdf1_pkg::Y_W-1:16])
                + $signed({23'd0, (y_sat[iirdf1_pkg::Y_W-1] && (y_sat[15:0] != '0))});

        if (y_sat[iirdf1_pkg::Y_W-1])
        begin
            dac_next = '0;
        end
        else if (y_sat[iirdf1_pkg::Y_W-2:28] != '0)
        begin
            dac_next = '1;
        end
        else
        begin
            dac_next = y_sat[27:20];
        end
    end

    // Sequencer, histories and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            tap_reg       <= '0;
            x0_reg        <= '0;
            fv_reg        <= '0;
            dac_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < iirdf1_pkg::HIST_DEPTH; i++)
            begin
                x_hist_reg[i] <= '0;
                y_hist_reg[i] <= '0;
            end
        end
        else
        begin
            // a new result in the same cycle keeps valid high
            if (out_valid_reg && out_ready && !fin_go)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        x0_reg    <= adc_sample;
                        tap_reg   <= '0;
                        state_reg <= S_FF;
                    end
                end
                S_FF:
                begin
                    if (tap_reg == iirdf1_pkg::TAP_W'(iirdf1_pkg::FF_ORDER))
                    begin
                        tap_reg   <= 3'd1;
                        state_reg <= S_FB_LO;
                    end
                    else
                    begin
                        tap_reg <= tap_reg + 3'd1;
                    end
                end
                S_FB_LO:
                begin
                    state_reg <= S_FB_HI;
                end
                S_FB_HI:
                begin
                    if (tap_reg == iirdf1_pkg::TAP_W'(iirdf1_pkg::FB_ORDER))
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        tap_reg   <= tap_reg + 3'd1;
                        state_reg <= S_FB_LO;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (fin_go)
                    begin
                        for (int i = iirdf1_pkg::HIST_DEPTH - 1; i > 0; i--)
                        begin
                            x_hist_reg[i] <= x_hist_reg[i-1];
                            y_hist_reg[i] <= y_hist_reg[i-1];
                        end
                        x_hist_reg[0] <= x0_reg;
                        y_hist_reg[0] <= y_sat;
                        fv_reg        <= fv_next;
                        dac_reg       <= dac_next;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Checks
    `IIRDF1_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_valid && in_ready, !in_ready)
    `IIRDF1_ASSERT_IMPL(a_result_from_fin, clk, rst_n, $rose(out_valid), $past(state_reg == S_FIN))
    `IIRDF1_ASSERT_IMPL(a_neg_dac_zero, clk, rst_n, out_valid && (filtered_value < 0), dac_code == '0)

endmodule

>>> hw/rtl/iirdf1_cfg.sv
// Coefficient register file of the filter: decodes configuration writes.
// Depends on iirdf1_pkg.
module iirdf1_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [iirdf1_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [iirdf1_pkg::CFG_DATA_W-1:0]    wr_data,
    output iirdf1_pkg::coef_t                    ff_coeff [iirdf1_pkg::FF_TAPS],
    output iirdf1_pkg::coef_t                    fb_coeff [iirdf1_pkg::FB_TAPS]
);

    iirdf1_pkg::coef_t                        ff_reg [iirdf1_pkg::FF_TAPS];
    logic [iirdf1_pkg::CFG_DATA_W-1:0]        fb12_reg;
    logic [iirdf1_pkg::CFG_DATA_W-1:0]        fb34_reg;

    // Register writes; out-of-range indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < iirdf1_pkg::FF_TAPS; i++)
            begin
                ff_reg[i] <= '0;
            end
            fb12_reg <= '0;
            fb34_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index) inside
                iirdf1_pkg::REG_FF_COEFF_0, iirdf1_pkg::REG_FF_COEFF_1,
                iirdf1_pkg::REG_FF_COEFF_2, iirdf1_pkg::REG_FF_COEFF_3,
                iirdf1_pkg::REG_FF_COEFF_4:
                begin
                    ff_reg[wr_index] <= $signed(wr_data[iirdf1_pkg::COEF_W-1:0]);
                end
                iirdf1_pkg::REG_FB_COEFFS_1_2:
                begin
                    fb12_reg <= wr_data;
                end
                iirdf1_pkg::REG_FB_COEFFS_3_4:
                begin
                    fb34_reg <= wr_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // Feedback words: low half is the nearer tap
    always_comb
    begin
        for (int i = 0; i < iirdf1_pkg::FF_TAPS; i++)
        begin
            ff_coeff[i] = ff_reg[i];
        end
        fb_coeff[0] = $signed(fb12_reg[31:0]);
        fb_coeff[1] = $signed(fb12_reg[63:32]);
        fb_coeff[2] = $signed(fb34_reg[31:0]);
        fb_coeff[3] = $signed(fb34_reg[63:32]);
    end

endmodule

>>> hw/rtl/iirdf1_mac.sv
// Shared multiply-accumulate unit: one 32x25 signed multiplier, a registered
// product, and a floor-shifting accumulator. Depends on iirdf1_pkg.
module iirdf1_mac (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  iirdf1_pkg::mac_op_t                       op,
    input  iirdf1_pkg::coef_t                         coef,
    input  logic signed [iirdf1_pkg::OPND_W-1:0]      operand,
    output logic signed [iirdf1_pkg::ACC_W-1:0]       acc
);

    logic signed [iirdf1_pkg::PROD_W-1:0]   prod_next;
    logic signed [iirdf1_pkg::PROD_W-1:0]   prod_reg;
    logic signed [iirdf1_pkg::PROD_W-1:0]   lo_reg;
    iirdf1_pkg::mac_kind_t                  kind_reg;
    logic                                   pvalid_reg;
    logic signed [iirdf1_pkg::ACC_W-1:0]    acc_reg;
    logic signed [iirdf1_pkg::ACC_W-1:0]    acc_next;
    logic signed [iirdf1_pkg::FB_SUM_W-1:0] fb_sum;
    logic signed [iirdf1_pkg::ACC_W-1:0]    ff_term;
    logic signed [iirdf1_pkg::ACC_W-1:0]    fb_term;

    // Multiply stage
    assign prod_next = iirdf1_pkg::PROD_W'(coef) * iirdf1_pkg::PROD_W'(operand);

    // b*x reduced by 12 bits, floor
    assign ff_term = iirdf1_pkg::ACC_W'($signed(prod_reg[iirdf1_pkg::PROD_W-1:12]));

    // a*y = (a*yh << 16) + a*yl, exact, then floor by 28 bits
    assign fb_sum  = (iirdf1_pkg::FB_SUM_W'(prod_reg) <<< 16)
                   + iirdf1_pkg::FB_SUM_W'(lo_reg);
    assign fb_term = $signed(fb_sum[iirdf1_pkg::FB_SUM_W-1:28]);

    // Accumulate stage
    always_comb
    begin
        acc_next = acc_reg;
        if (op.clear)
        begin
            acc_next = '0;
        end
        else if (pvalid_reg)
        begin
            case (kind_reg)
                iirdf1_pkg::KIND_FF:    acc_next = acc_reg + ff_term;
                iirdf1_pkg::KIND_FB_HI: acc_next = acc_reg + fb_term;
                default:                acc_next = acc_reg;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= 1'b0;
            kind_reg   <= iirdf1_pkg::KIND_FF;
            acc_reg    <= '0;
        end
        else
        begin
            pvalid_reg <= op.mul_en;
            kind_reg   <= op.kind;
            acc_reg    <= acc_next;
        end
    end

    // Product and low-half registers
    always_ff @(posedge clk)
    begin
        if (op.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (pvalid_reg && kind_reg == iirdf1_pkg::KIND_FB_LO)
        begin
            lo_reg <= prod_reg;
        end
    end

    assign acc = acc_reg;

endmodule
